[rtl/mme_pkg.sv]
// Package for the matrix multiply engine: widths, item kinds, register
// indexes, state encoding and the control structs shared by the modules.
// No dependencies.
package mme_pkg;

  localparam int DEF_MAX_DIM   = 8;
  localparam int DEF_FRAC_BITS = 16;

  localparam int DATA_W  = 32;
  localparam int KIND_W  = 2;
  localparam int POS_W   = 3;
  localparam int DIM_W   = 4;
  localparam int CFG_IDX_W = 2;

  localparam logic [KIND_W-1:0] KIND_WR_A = 2'd0;
  localparam logic [KIND_W-1:0] KIND_WR_B = 2'd1;
  localparam logic [KIND_W-1:0] KIND_MUL  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_A_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_A_COLS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_B_ROWS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_B_COLS = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_RUN,
    ST_WAIT,
    ST_NEXT
  } mme_state_t;

  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mme_ctl_t;

  typedef struct packed {
    logic              valid;
    logic              sat;
    logic [DATA_W-1:0] value;
  } mme_res_t;

endpackage

[rtl/matrix_multiply_engine.sv]
// Matrix multiply engine top level: configuration registers, walk sequencer,
// element stores and result register. Depends on mme_pkg, mme_ram, mme_mac.
//
// Usage:
//   cfg_we/cfg_index/cfg_data set a_rows, a_cols, b_rows, b_cols (0 acts as 1,
//   values above MAX_DIM act as MAX_DIM). Write them only while idle.
//   Input beats of kind 0/1 write one element of A or B into its store and
//   are taken one per cycle while idle; writes outside MAX_DIM are dropped, kind 3 is
//   dropped. A kind 2 beat starts the product walk; in_stall is high until
//   the last result has been loaded into the output register.
//   Each product element is a dot product of a_cols terms, one store read
//   pair per cycle; it passes the store read, product and accumulator registers
//   into the output register, and an element's reads start only after the previous result is loaded.
//   The next element is issued once the output register is free, so a
//   stalled receiver holds the walk; results leave in row-major order with
//   out_last on the final one. A dimension mismatch gives one beat with
//   out_dims_error and out_last set.
//   Reset clears the registers to 1 and empties the pipeline; the stores
//   hold no reset value and must be written before they are read.
module matrix_multiply_engine
  import mme_pkg::*;
#(
  parameter int MAX_DIM   = DEF_MAX_DIM,
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [KIND_W-1:0]    in_kind,
  input  logic [POS_W-1:0]     in_row,
  input  logic [POS_W-1:0]     in_col,
  input  logic [DATA_W-1:0]    in_value,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [POS_W-1:0]     out_row,
  output logic [POS_W-1:0]     out_col,
  output logic [DATA_W-1:0]    out_value,
  output logic                 out_saturated,
  output logic                 out_dims_error,
  output logic                 out_last
);

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int IDX_W  = $clog2(MAX_DIM);
  localparam int CNT_W  = $clog2(MAX_DIM + 1);

  logic [DIM_W-1:0] a_rows_r, a_cols_r, b_rows_r, b_cols_r;
  logic [CNT_W-1:0] ar, ac, br, bc;

  mme_state_t state_r, state_nxt;
  logic [IDX_W-1:0] i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;

  logic in_acc, in_range, we_a, we_b;
  logic [ADDR_W-1:0] waddr, raddr_a, raddr_b;
  logic [DATA_W-1:0] rdata_a, rdata_b;
  mme_ctl_t issue;
  mme_res_t mac_res;

  logic out_free, k_last, el_last;
  logic load_err, load_res;
  logic out_valid_r, out_valid_nxt;
  logic [POS_W-1:0]  out_row_r, out_col_r;
  logic [DATA_W-1:0] out_value_r;
  logic out_sat_r, out_err_r, out_last_r;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_rows_r <= DIM_W'(1);
      a_cols_r <= DIM_W'(1);
      b_rows_r <= DIM_W'(1);
      b_cols_r <= DIM_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_A_ROWS: a_rows_r <= cfg_data;
        CFG_A_COLS: a_cols_r <= cfg_data;
        CFG_B_ROWS: b_rows_r <= cfg_data;
        CFG_B_COLS: b_cols_r <= cfg_data;
        default: ;
      endcase
    end
  end

  function automatic logic [CNT_W-1:0] dim_clamp(input logic [DIM_W-1:0] v);
    logic [CNT_W-1:0] r;
    if (v == '0) begin
      r = CNT_W'(1);
    end else if (int'(v) > MAX_DIM) begin
      r = CNT_W'(MAX_DIM);
    end else begin
      r = CNT_W'(v);
    end
    return r;
  endfunction

  assign ar = dim_clamp(a_rows_r);
  assign ac = dim_clamp(a_cols_r);
  assign br = dim_clamp(b_rows_r);
  assign bc = dim_clamp(b_cols_r);

  // element stores
  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign in_range = (int'(in_row) < MAX_DIM) && (int'(in_col) < MAX_DIM);
  assign we_a     = in_acc && in_range && (in_kind == KIND_WR_A);
  assign we_b     = in_acc && in_range && (in_kind == KIND_WR_B);
  assign waddr    = ADDR_W'(int'(in_row) * MAX_DIM + int'(in_col));
  assign raddr_a  = ADDR_W'(int'(i_r) * MAX_DIM + int'(k_r));
  assign raddr_b  = ADDR_W'(int'(k_r) * MAX_DIM + int'(j_r));

  mme_ram #(.DEPTH(DEPTH), .ADDR_W(ADDR_W), .WIDTH(DATA_W)) u_left (
    .clk(clk), .we(we_a), .waddr(waddr), .wdata(in_value),
    .raddr(raddr_a), .rdata(rdata_a)
  );

  mme_ram #(.DEPTH(DEPTH), .ADDR_W(ADDR_W), .WIDTH(DATA_W)) u_right (
    .clk(clk), .we(we_b), .waddr(waddr), .wdata(in_value),
    .raddr(raddr_b), .rdata(rdata_b)
  );

  mme_mac #(.MAX_DIM(MAX_DIM), .FRAC_BITS(FRAC_BITS)) u_mac (
    .clk(clk), .rst_n(rst_n), .ctl_i(issue),
    .a_data(rdata_a), .b_data(rdata_b), .res_o(mac_res)
  );

  // walk sequencer
  assign out_free = !out_valid_r || !out_stall;
  assign k_last   = (CNT_W'(k_r) == ac - CNT_W'(1));
  assign el_last  = (CNT_W'(i_r) == ar - CNT_W'(1)) && (CNT_W'(j_r) == bc - CNT_W'(1));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && in_kind == KIND_MUL) begin
          state_nxt = ST_START;
        end
      end
      ST_START: begin
        if (out_free) begin
          state_nxt = (ac != br) ? ST_IDLE : ST_RUN;
        end
      end
      ST_RUN: begin
        if (k_last) begin
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (mac_res.valid) begin
          state_nxt = el_last ? ST_IDLE : ST_NEXT;
        end
      end
      ST_NEXT: begin
        if (out_free) begin
          state_nxt = ST_RUN;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    i_nxt       = i_r;
    j_nxt       = j_r;
    k_nxt       = k_r;
    issue       = '0;
    load_err    = 1'b0;
    load_res    = 1'b0;
    case (state_r)
      ST_START: begin
        i_nxt    = '0;
        j_nxt    = '0;
        k_nxt    = '0;
        load_err = out_free && (ac != br);
      end
      ST_RUN: begin
        issue.valid = 1'b1;
        issue.first = (k_r == '0);
        issue.last  = k_last;
        if (!k_last) begin
          k_nxt = k_r + IDX_W'(1);
        end
      end
      ST_WAIT: begin
        load_res = mac_res.valid;
      end
      ST_NEXT: begin
        if (out_free) begin
          k_nxt = '0;
          if (CNT_W'(j_r) == bc - CNT_W'(1)) begin
            j_nxt = '0;
            i_nxt = i_r + IDX_W'(1);
          end else begin
            j_nxt = j_r + IDX_W'(1);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r <= i_nxt;
    j_r <= j_nxt;
    k_r <= k_nxt;
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_err || load_res) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_err) begin
      out_row_r   <= '0;
      out_col_r   <= '0;
      out_value_r <= '0;
      out_sat_r   <= 1'b0;
      out_err_r   <= 1'b1;
      out_last_r  <= 1'b1;
    end else if (load_res) begin
      out_row_r   <= POS_W'(i_r);
      out_col_r   <= POS_W'(j_r);
      out_value_r <= mac_res.value;
      out_sat_r   <= mac_res.sat;
      out_err_r   <= 1'b0;
      out_last_r  <= el_last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_row        = out_row_r;
  assign out_col        = out_col_r;
  assign out_value      = out_value_r;
  assign out_saturated  = out_sat_r;
  assign out_dims_error = out_err_r;
  assign out_last       = out_last_r;

  a_res_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    mac_res.valid |-> state_r == ST_WAIT)
    else $error("mac result outside wait state");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (load_res || load_err) |-> (!out_valid_r || !out_stall))
    else $error("output register overwritten");

  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_err_r) |-> (out_last_r && out_value_r == '0))
    else $error("error beat malformed");

  a_k_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RUN |-> CNT_W'(k_r) < ac)
    else $error("inner index past a_cols");

endmodule

[rtl/mme_ram.sv]
// Single write port, single read port synchronous RAM with a registered read.
// Depends on mme_pkg for the default data width and depth.
module mme_ram
  import mme_pkg::*;
#(
  parameter int DEPTH  = DEF_MAX_DIM * DEF_MAX_DIM,
  parameter int ADDR_W = $clog2(DEPTH),
  parameter int WIDTH  = DATA_W
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/mme_mac.sv]
// Multiply-accumulate datapath: registered 32x32 multiply, exact accumulate,
// then round-to-nearest, shift and saturate. Depends on mme_pkg.
module mme_mac
  import mme_pkg::*;
#(
  parameter int MAX_DIM   = DEF_MAX_DIM,
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  mme_ctl_t          ctl_i,
  input  logic [DATA_W-1:0] a_data,
  input  logic [DATA_W-1:0] b_data,
  output mme_res_t          res_o
);

  localparam int PROD_W = 2 * DATA_W;
  localparam int ACC_W  = PROD_W + $clog2(MAX_DIM);
  localparam logic [ACC_W-1:0] RND = (ACC_W'(1) << FRAC_BITS) >> 1;

  mme_ctl_t ctl1_r, ctl2_r, ctl3_r;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic [ACC_W-1:0] acc_r, acc_nxt, prod_ext;
  logic [ACC_W-1:0] rounded;
  logic signed [ACC_W-1:0] shifted;
  logic fits;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      ctl2_r <= '0;
      ctl3_r <= '0;
    end else begin
      ctl1_r <= ctl_i;
      ctl2_r <= ctl1_r;
      ctl3_r <= ctl2_r;
    end
  end

  assign prod_nxt = $signed(a_data) * $signed(b_data);
  assign prod_ext = {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};
  assign acc_nxt  = ctl2_r.first ? prod_ext : acc_r + prod_ext;

  always_ff @(posedge clk) begin
    if (ctl1_r.valid) begin
      prod_r <= prod_nxt;
    end
    if (ctl2_r.valid) begin
      acc_r <= acc_nxt;
    end
  end

  assign rounded = acc_r + RND;
  assign shifted = $signed(rounded) >>> FRAC_BITS;
  assign fits    = (&shifted[ACC_W-1:DATA_W-1]) || !(|shifted[ACC_W-1:DATA_W-1]);

  always_comb begin
    res_o.valid = ctl3_r.valid && ctl3_r.last;
    res_o.sat   = !fits;
    if (fits) begin
      res_o.value = shifted[DATA_W-1:0];
    end else if (shifted[ACC_W-1]) begin
      res_o.value = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      res_o.value = {1'b0, {(DATA_W-1){1'b1}}};
    end
  end

endmodule
